@@ hdl/sha_pkg.sv @@
// SHA-256 constants, the initial-hash function and the shared word type.
package sha_pkg;

    localparam int WordW    = 32;
    localparam int WinDepth = 16;
    localparam int WinAw    = 4;
    localparam int WinRdN   = 4;
    localparam int HashN    = 8;
    localparam int HashAw   = 3;

    typedef logic [WordW-1:0] t_word;

    function automatic t_word f_iv(input logic [HashAw-1:0] idx);
        t_word v;
        unique case (idx)
            3'd0: v = 32'h6A09E667;
            3'd1: v = 32'hBB67AE85;
            3'd2: v = 32'h3C6EF372;
            3'd3: v = 32'hA54FF53A;
            3'd4: v = 32'h510E527F;
            3'd5: v = 32'h9B05688C;
            3'd6: v = 32'h1F83D9AB;
            default: v = 32'h5BE0CD19;
        endcase
        return v;
    endfunction

    localparam t_word KTab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

@@ hdl/sha_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module sha_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/sha_round.sv @@
// One SHA-256 compression round on the working variables.
module sha_round
    import sha_pkg::*;
(
    input  t_word i_wv [HashN],
    input  t_word i_kw,
    output t_word o_wv [HashN]
);
    t_word a, e, s0, s1, ch, maj, t1, t2;

    always_comb begin
        a   = i_wv[0];
        e   = i_wv[4];
        s1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        ch  = (e & i_wv[5]) ^ (~e & i_wv[6]);
        s0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        maj = (a & i_wv[1]) ^ (a & i_wv[2]) ^ (i_wv[1] & i_wv[2]);
        t1  = i_wv[7] + s1 + ch + i_kw;
        t2  = s0 + maj;
        o_wv[7] = i_wv[6];
        o_wv[6] = i_wv[5];
        o_wv[5] = i_wv[4];
        o_wv[4] = i_wv[3] + t1;
        o_wv[3] = i_wv[2];
        o_wv[2] = i_wv[1];
        o_wv[1] = i_wv[0];
        o_wv[0] = t1 + t2;
    end
endmodule

@@ hdl/sha256_message_digest_core.sv @@
// SHA-256 streaming core: padding, schedule RAM, round sequencer, digest out.
//
// Input beats on s_axis: tdata[31:0] message word (first byte in [31:24]),
// tdata[34:32] valid byte count; tlast marks the final word. A short count
// only matters on the last word. Padding and the 64-bit length are added
// internally, with an extra block where the tail leaves no room.
// Output beats on m_axis: tdata[31:0] digest word, tdata[34:32] index
// (0 is most significant); tlast on the eighth word.
// Words are taken one a cycle while a block fills; each full block then
// takes one load, 64 rounds at one a cycle and one hash update, and no
// words are taken until these are done.
// Padding words are written one a cycle. The schedule window sits in four
// mirrored 16-entry RAMs (common write port, one registered read each) so
// that a round can fetch all four schedule taps; addresses run one round
// ahead. The digest is offered once the last block has been hashed; the
// eight beats leave one a cycle and a stalled receiver holds the core in
// that state with input closed.
// Reset returns the core to the initial hash and an empty message; input is
// not accepted while reset is held.
module sha256_message_digest_core
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [31:0] data_word, [34:32] byte_count
    input  logic        s_axis_tlast,  // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] digest_index
    output logic        m_axis_tlast   // digest_last
);
    typedef enum logic [2:0] {
        ST_FILL, ST_PAD, ST_INIT, ST_ROUND, ST_UPD, ST_OUT
    } t_state;

    t_state            r_state;
    logic [WinAw-1:0]  r_pos;
    logic [63:0]       r_bits;
    logic              r_padding;
    logic              r_need80;
    logic              r_lenok;
    logic              r_final;
    logic [5:0]        r_rnd;
    logic [HashAw-1:0] r_oidx;
    t_word             r_hash [HashN];
    t_word             r_wv   [HashN];
    t_word             wv_next [HashN];

    // Schedule window RAMs: identical contents, one read tap each
    logic             we;
    logic [WinAw-1:0] waddr;
    t_word            wdata;
    logic [5:0]       rnd_rd;
    logic [WinAw-1:0] raddr [WinRdN];
    t_word            rdata [WinRdN];

    for (genvar g = 0; g < WinRdN; g++) begin : g_win
        sha_ram #(.Width(WordW), .Depth(WinDepth)) u_win (
            .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
            .i_raddr(raddr[g]), .o_rdata(rdata[g])
        );
    end

    logic [2:0] bc;
    t_word      in_word, pad_word, mask, w_cur, s0w, s1w, x2, x15, kw;
    logic       acc;

    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = i_rst_n && (r_state == ST_FILL);
    assign bc = (s_axis_tdata[34:32] > 3'd4 || !s_axis_tlast) ? 3'd4
                : s_axis_tdata[34:32];

    always_comb begin
        unique case (bc)
            3'd0: mask = 32'h0;
            3'd1: mask = 32'hFF000000;
            3'd2: mask = 32'hFFFF0000;
            3'd3: mask = 32'hFFFFFF00;
            default: mask = 32'hFFFFFFFF;
        endcase
        in_word = s_axis_tdata[31:0] & mask;
        unique case (bc)
            3'd0: in_word = in_word | 32'h80000000;
            3'd1: in_word = in_word | 32'h00800000;
            3'd2: in_word = in_word | 32'h00008000;
            3'd3: in_word = in_word | 32'h00000080;
            default: ;
        endcase
        // length words only go into a block that still has room for them
        if (r_need80) begin
            pad_word = 32'h80000000;
        end else if (r_lenok && r_pos == 4'd14) begin
            pad_word = r_bits[63:32];
        end else if (r_lenok && r_pos == 4'd15) begin
            pad_word = r_bits[31:0];
        end else begin
            pad_word = '0;
        end
    end

    // Read addresses for the next round: w[r], w[r-2], w[r-7], w[r-15]
    always_comb begin
        rnd_rd   = (r_state == ST_ROUND) ? r_rnd + 6'd1 : 6'd0;
        raddr[0] = rnd_rd[3:0];
        raddr[1] = WinAw'(rnd_rd - 6'd2);
        raddr[2] = WinAw'(rnd_rd - 6'd7);
        raddr[3] = WinAw'(rnd_rd - 6'd15);
    end

    // Round word: first 16 from the window, then expanded in place
    always_comb begin
        x2  = rdata[1];
        x15 = rdata[3];
        s1w = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
        s0w = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
        if (r_rnd < 6'd16) begin
            w_cur = rdata[0];
        end else begin
            w_cur = s1w + rdata[2] + s0w + rdata[0];
        end
        kw = KTab[r_rnd] + w_cur;
    end

    sha_round u_round (.i_wv(r_wv), .i_kw(kw), .o_wv(wv_next));

    always_comb begin
        we    = 1'b0;
        waddr = r_pos;
        wdata = in_word;
        if (r_state == ST_FILL && acc) begin
            we = 1'b1;
        end else if (r_state == ST_PAD) begin
            we    = 1'b1;
            wdata = pad_word;
        end else if (r_state == ST_ROUND && r_rnd >= 6'd16) begin
            we    = 1'b1;
            waddr = r_rnd[3:0];
            wdata = w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_pos     <= '0;
            r_bits    <= '0;
            r_padding <= 1'b0;
            r_need80  <= 1'b0;
            r_lenok   <= 1'b0;
            r_final   <= 1'b0;
            r_rnd     <= '0;
            r_oidx    <= '0;
            for (int k = 0; k < HashN; k++) begin
                r_hash[k] <= f_iv(HashAw'(k));
                r_wv[k]   <= '0;
            end
        end else begin
            unique case (r_state)
                ST_FILL: begin
                    if (acc) begin
                        r_pos      <= r_pos + 1'b1;
                        r_bits     <= r_bits + 64'({bc, 3'b000});
                        if (s_axis_tlast) begin
                            r_padding <= 1'b1;
                            r_need80  <= (bc == 3'd4);
                            r_lenok   <= (bc != 3'd4) && (r_pos <= 4'd13);
                        end
                        if (r_pos == 4'd15) begin
                            r_state <= ST_INIT;
                        end else if (s_axis_tlast) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_pos      <= r_pos + 1'b1;
                    r_need80   <= 1'b0;
                    if (r_need80) begin
                        r_lenok <= (r_pos <= 4'd13);
                    end
                    if (r_pos == 4'd15) begin
                        r_final <= r_lenok;
                        r_state <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    r_wv    <= r_hash;
                    r_rnd   <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_wv  <= wv_next;
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == 6'd63) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    for (int k = 0; k < HashN; k++) begin
                        r_hash[k] <= r_hash[k] + r_wv[k];
                    end
                    if (r_final) begin
                        r_state <= ST_OUT;
                        r_oidx  <= '0;
                    end else if (r_padding) begin
                        r_lenok <= 1'b1;
                        r_state <= ST_PAD;
                    end else begin
                        r_state <= ST_FILL;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            r_state   <= ST_FILL;
                            r_bits    <= '0;
                            r_pos     <= '0;
                            r_padding <= 1'b0;
                            r_final   <= 1'b0;
                            for (int k = 0; k < HashN; k++) begin
                                r_hash[k] <= f_iv(HashAw'(k));
                            end
                        end
                    end
                end
                default: r_state <= ST_FILL;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {5'd0, r_oidx, r_hash[r_oidx]};
    assign m_axis_tlast  = (r_oidx == 3'd7);

    a_out_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted during digest output");
    a_round_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == 6'd63) |=> r_state == ST_UPD)
        else $error("round sequence did not end in update");
    a_final_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> r_pos == 4'd0)
        else $error("window position not aligned at digest");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> r_bits == 64'd0)
        else $error("bit count not cleared after digest");
endmodule
